>>> rtl/core/gyro_bp_pkg.sv
// ----------------------------------------------------------------------------
// gyro_bp_pkg
// Shared types and constants for the three-axis gyro band-pass filter.
// ----------------------------------------------------------------------------
package gyro_bp_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned HIST_W     = 48;
  localparam int unsigned HALF_W     = 24;
  localparam int unsigned TAPS       = 4;
  localparam int unsigned AXES       = 3;
  localparam int unsigned ROW_W      = TAPS * HIST_W;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // Q3.28 coefficient reset values
  localparam logic [COEF_W-1:0] RST_INPUT_GAIN     = 32'sd139394;
  localparam logic [COEF_W-1:0] RST_FEEDBACK_OLDEST = -32'sd111778170;
  localparam logic [COEF_W-1:0] RST_FEEDBACK_THIRD  = 32'sd531467613;
  localparam logic [COEF_W-1:0] RST_FEEDBACK_SECOND = -32'sd995400050;
  localparam logic [COEF_W-1:0] RST_FEEDBACK_NEWEST = 32'sd844143197;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_GAIN      = 3'd0,
    REG_FEEDBACK_OLDEST = 3'd1,
    REG_FEEDBACK_THIRD  = 3'd2,
    REG_FEEDBACK_SECOND = 3'd3,
    REG_FEEDBACK_NEWEST = 3'd4
  } cfg_reg_e;

  // frame axes, also the history row address
  typedef enum logic [AXIS_W-1:0] {
    AXIS_FX = 2'd0,
    AXIS_FY = 2'd1,
    AXIS_FZ = 2'd2
  } axis_e;

  typedef struct packed {
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] fb_oldest;
    logic [COEF_W-1:0] fb_third;
    logic [COEF_W-1:0] fb_second;
    logic [COEF_W-1:0] fb_newest;
  } coef_t;

  typedef struct packed {
    logic             valid;
    axis_e            axis;
    logic [RAW_W-1:0] raw;
  } issue_t;

  typedef struct packed {
    logic             en;
    axis_e            addr;
    logic [ROW_W-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic              valid;
    axis_e             axis;
    logic [RATE_W-1:0] rate;
  } axis_res_t;

endpackage

>>> rtl/core/three_axis_gyro_bandpass_iir.sv
// ----------------------------------------------------------------------------
// three_axis_gyro_bandpass_iir
// Fourth-order band-pass IIR on three gyro axes, fixed point, Q15.16 out.
// ----------------------------------------------------------------------------
// One item is three raw 16-bit gyro counts; device x and y are swapped into
// frame y and x. Each frame axis keeps four Q23.24 recursive values in a
// small history memory (one row per axis). The axes share one multiply /
// accumulate pipeline and go through it one per cycle, so the block takes
// a new item as soon as the last axis of the previous one issues, while
// that item is still in the pipeline; the per-axis recursion still closes
// between two visits of an axis (the new row is forwarded around the memory
// to the next read of the same axis). Finished items wait in a 4-deep output
// queue; besides the axis slots, input ready drops only when that queue plus
// items in flight would be full. Coefficients are Q3.28 and may be written
// any time the block is idle; indexes above 4 are ignored.
// ----------------------------------------------------------------------------
module three_axis_gyro_bandpass_iir
  import gyro_bp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAW_W-1:0]     raw_dev_x_i,
  input  logic [RAW_W-1:0]     raw_dev_y_i,
  input  logic [RAW_W-1:0]     raw_dev_z_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RATE_W-1:0]    rate_x_o,
  output logic [RATE_W-1:0]    rate_y_o,
  output logic [RATE_W-1:0]    rate_z_o
);

  coef_t                 coef_q;
  logic                  busy_q;
  axis_e                 axis_q;
  logic [RAW_W-1:0]      raw_fx_q;
  logic [RAW_W-1:0]      raw_fy_q;
  logic [RAW_W-1:0]      raw_fz_q;
  logic [FIFO_CNT_W-1:0] credit_q;
  logic                  in_acc;
  logic                  out_acc;
  issue_t                issue;
  hist_wr_t              hist_wr;
  logic [ROW_W-1:0]      rd_row;
  axis_res_t             res;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.gain      <= RST_INPUT_GAIN;
      coef_q.fb_oldest <= RST_FEEDBACK_OLDEST;
      coef_q.fb_third  <= RST_FEEDBACK_THIRD;
      coef_q.fb_second <= RST_FEEDBACK_SECOND;
      coef_q.fb_newest <= RST_FEEDBACK_NEWEST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INPUT_GAIN:      coef_q.gain      <= cfg_wdata_i;
        REG_FEEDBACK_OLDEST: coef_q.fb_oldest <= cfg_wdata_i;
        REG_FEEDBACK_THIRD:  coef_q.fb_third  <= cfg_wdata_i;
        REG_FEEDBACK_SECOND: coef_q.fb_second <= cfg_wdata_i;
        REG_FEEDBACK_NEWEST: coef_q.fb_newest <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Ready as soon as the issue slot frees (last axis issuing this cycle) and
  // a queue slot is reserved for the result.
  assign in_ready_o = (!busy_q || (axis_q == AXIS_FZ)) &&
                      (credit_q < FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  // issue sequencer: frame x, y, z on consecutive cycles
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      axis_q   <= AXIS_FX;
      credit_q <= '0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        axis_q <= AXIS_FX;
      end else if (busy_q) begin
        case (axis_q)
          AXIS_FX: axis_q <= AXIS_FY;
          AXIS_FY: axis_q <= AXIS_FZ;
          default: busy_q <= 1'b0;
        endcase
      end
      if (in_acc && !out_acc) begin
        credit_q <= credit_q + 1'b1;
      end else if (out_acc && !in_acc) begin
        credit_q <= credit_q - 1'b1;
      end
    end
  end

  // raw counts held by frame axis (x/y swap happens here)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_fx_q <= raw_dev_y_i;
      raw_fy_q <= raw_dev_x_i;
      raw_fz_q <= raw_dev_z_i;
    end
  end

  always_comb begin
    issue.valid = busy_q;
    issue.axis  = axis_q;
    case (axis_q)
      AXIS_FX: issue.raw = raw_fx_q;
      AXIS_FY: issue.raw = raw_fy_q;
      default: issue.raw = raw_fz_q;
    endcase
  end

  gyro_bp_hist_mem u_hist_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (axis_q),
    .wr_i      (hist_wr),
    .rd_data_o (rd_row)
  );

  gyro_bp_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .coef_i    (coef_q),
    .rd_row_i  (rd_row),
    .hist_wr_o (hist_wr),
    .res_o     (res)
  );

  gyro_bp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .rate_x_o    (rate_x_o),
    .rate_y_o    (rate_y_o),
    .rate_z_o    (rate_z_o)
  );

endmodule

>>> rtl/core/gyro_bp_hist_mem.sv
// ----------------------------------------------------------------------------
// gyro_bp_hist_mem
// History memory: one 4-tap row per frame axis, registered read, with row
// valid bits so never-written rows read as zero after reset.
// ----------------------------------------------------------------------------
module gyro_bp_hist_mem
  import gyro_bp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  axis_e            rd_addr_i,
  input  hist_wr_t         wr_i,
  output logic [ROW_W-1:0] rd_data_o
);

  logic [ROW_W-1:0] mem_q [AXES];
  logic [ROW_W-1:0] rd_data_q;
  logic [AXES-1:0]  row_vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= row_vld_q[rd_addr_i];
      if (wr_i.en) begin
        row_vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/core/gyro_bp_datapath.sv
// ----------------------------------------------------------------------------
// gyro_bp_datapath
// Per-axis filter pipeline: products, partial sums, recursive value with
// write-back and forwarding, then output rounding and saturation.
// ----------------------------------------------------------------------------
module gyro_bp_datapath
  import gyro_bp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  issue_t           issue_i,
  input  coef_t            coef_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output hist_wr_t         hist_wr_o,
  output axis_res_t        res_o
);

  localparam int unsigned GAIN_W = RAW_W + COEF_W;        // 48
  localparam int unsigned PHI_W  = HALF_W + COEF_W;       // 56
  localparam int unsigned PLO_W  = HALF_W + 1 + COEF_W;   // 57
  localparam int unsigned HI_W   = PHI_W + 2;             // 58
  localparam int unsigned LO_W   = PLO_W + 2;             // 59
  localparam int unsigned V_W    = HI_W + HALF_W + 1;     // 83
  localparam int unsigned W_SH   = HALF_W + 4;            // Q.52 -> Q.24
  localparam int unsigned WF_W   = V_W - W_SH;            // 55
  localparam int unsigned S_W    = HIST_W + 3;            // 51
  localparam int unsigned OUT_SH = 8;                     // Q.24 -> Q.16
  localparam int unsigned Q_W    = S_W - OUT_SH;          // 43

  localparam logic signed [V_W-1:0] W_ROUND = V_W'(64'd1 << (W_SH - 1));
  localparam logic signed [S_W-1:0] O_ROUND = S_W'(64'd1 << (OUT_SH - 1));

  // ---- stage 1: read data aligned, forward, multiply
  logic                     s1_vld_q;
  axis_e                    s1_axis_q;
  logic [RAW_W-1:0]         s1_raw_q;
  logic                     fwd_vld_q;
  axis_e                    fwd_axis_q;
  logic [ROW_W-1:0]         fwd_row_q;
  logic [ROW_W-1:0]         row_s1;
  logic signed [COEF_W-1:0] coef_tap [TAPS];
  logic signed [HALF_W-1:0] hh_tap [TAPS];
  logic signed [HALF_W:0]   hl_tap [TAPS];
  logic signed [PHI_W-1:0]  p_hi_d [TAPS];
  logic signed [PLO_W-1:0]  p_lo_d [TAPS];
  logic signed [GAIN_W-1:0] p_gain_d;

  // ---- stage 2: partial sums
  logic                     s2_vld_q;
  axis_e                    s2_axis_q;
  logic [ROW_W-1:0]         s2_row_q;
  logic signed [PHI_W-1:0]  p_hi_q [TAPS];
  logic signed [PLO_W-1:0]  p_lo_q [TAPS];
  logic signed [GAIN_W-1:0] p_gain_q;
  logic signed [HI_W-1:0]   hi_sum_d;
  logic signed [LO_W-1:0]   lo_sum_d;

  // ---- stage 3: round, clamp, write back
  logic                     s3_vld_q;
  axis_e                    s3_axis_q;
  logic [ROW_W-1:0]         s3_row_q;
  logic signed [HI_W-1:0]   hi_sum_q;
  logic signed [LO_W-1:0]   lo_sum_q;
  logic signed [V_W-1:0]    v_sum;
  logic signed [WF_W-1:0]   w_full;
  logic signed [HIST_W-1:0] w_d;

  // ---- stage 4: output
  logic                     s4_vld_q;
  axis_e                    s4_axis_q;
  logic signed [HIST_W-1:0] w_q;
  logic signed [HIST_W-1:0] h0_q;
  logic signed [HIST_W-1:0] h2_q;
  logic signed [S_W-1:0]    s_sum;
  logic signed [Q_W-1:0]    q_val;
  logic [RATE_W-1:0]        rate_d;

  always_comb begin
    row_s1 = (fwd_vld_q && (fwd_axis_q == s1_axis_q)) ? fwd_row_q : rd_row_i;
    coef_tap[0] = $signed(coef_i.fb_oldest);
    coef_tap[1] = $signed(coef_i.fb_third);
    coef_tap[2] = $signed(coef_i.fb_second);
    coef_tap[3] = $signed(coef_i.fb_newest);
    for (int t = 0; t < TAPS; t++) begin
      hh_tap[t] = $signed(row_s1[t*HIST_W+HALF_W +: HALF_W]);
      hl_tap[t] = $signed({1'b0, row_s1[t*HIST_W +: HALF_W]});
      p_hi_d[t] = hh_tap[t] * coef_tap[t];
      p_lo_d[t] = hl_tap[t] * coef_tap[t];
    end
    p_gain_d = $signed(s1_raw_q) * $signed(coef_i.gain);
  end

  always_comb begin
    hi_sum_d = HI_W'(p_gain_q) + HI_W'(p_hi_q[0]) + HI_W'(p_hi_q[1])
             + HI_W'(p_hi_q[2]) + HI_W'(p_hi_q[3]);
    lo_sum_d = LO_W'(p_lo_q[0]) + LO_W'(p_lo_q[1])
             + LO_W'(p_lo_q[2]) + LO_W'(p_lo_q[3]);
  end

  always_comb begin
    v_sum  = (V_W'(hi_sum_q) <<< HALF_W) + V_W'(lo_sum_q) + W_ROUND;
    w_full = v_sum[V_W-1:W_SH];
    if (w_full[WF_W-1:HIST_W-1] == '0 || w_full[WF_W-1:HIST_W-1] == '1) begin
      w_d = w_full[HIST_W-1:0];
    end else begin
      w_d = w_full[WF_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    hist_wr_o.en   = s3_vld_q;
    hist_wr_o.addr = s3_axis_q;
    hist_wr_o.data = {w_d, s3_row_q[ROW_W-1:HIST_W]};
  end

  always_comb begin
    s_sum = S_W'(h0_q) + S_W'(w_q) - (S_W'(h2_q) <<< 1) + O_ROUND;
    q_val = s_sum[S_W-1:OUT_SH];
    if (q_val[Q_W-1:RATE_W-1] == '0 || q_val[Q_W-1:RATE_W-1] == '1) begin
      rate_d = q_val[RATE_W-1:0];
    end else begin
      rate_d = q_val[Q_W-1] ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    end
    res_o.valid = s4_vld_q;
    res_o.axis  = s4_axis_q;
    res_o.rate  = rate_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue_i.valid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      fwd_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_axis_q  <= issue_i.axis;
    s1_raw_q   <= issue_i.raw;
    s2_axis_q  <= s1_axis_q;
    s2_row_q   <= row_s1;
    p_hi_q     <= p_hi_d;
    p_lo_q     <= p_lo_d;
    p_gain_q   <= p_gain_d;
    s3_axis_q  <= s2_axis_q;
    s3_row_q   <= s2_row_q;
    hi_sum_q   <= hi_sum_d;
    lo_sum_q   <= lo_sum_d;
    fwd_axis_q <= s3_axis_q;
    fwd_row_q  <= hist_wr_o.data;
    s4_axis_q  <= s3_axis_q;
    w_q        <= w_d;
    h0_q       <= $signed(s3_row_q[HIST_W-1:0]);
    h2_q       <= $signed(s3_row_q[2*HIST_W +: HIST_W]);
  end

endmodule

>>> rtl/core/gyro_bp_out_buf.sv
// ----------------------------------------------------------------------------
// gyro_bp_out_buf
// Gathers the three axis rates of an item and queues finished items.
// ----------------------------------------------------------------------------
module gyro_bp_out_buf
  import gyro_bp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  axis_res_t         res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [RATE_W-1:0] rate_x_o,
  output logic [RATE_W-1:0] rate_y_o,
  output logic [RATE_W-1:0] rate_z_o
);

  typedef struct packed {
    logic [RATE_W-1:0] x;
    logic [RATE_W-1:0] y;
    logic [RATE_W-1:0] z;
  } entry_t;

  logic [RATE_W-1:0]     rate_x_q;
  logic [RATE_W-1:0]     rate_y_q;
  entry_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push;
  logic                  pop;

  assign push        = res_i.valid && (res_i.axis == AXIS_FZ);
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign rate_x_o    = fifo_q[rd_ptr_q].x;
  assign rate_y_o    = fifo_q[rd_ptr_q].y;
  assign rate_z_o    = fifo_q[rd_ptr_q].z;

  always_ff @(posedge clk_i) begin
    if (res_i.valid && (res_i.axis == AXIS_FX)) begin
      rate_x_q <= res_i.rate;
    end
    if (res_i.valid && (res_i.axis == AXIS_FY)) begin
      rate_y_q <= res_i.rate;
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= '{x: rate_x_q, y: rate_y_q, z: res_i.rate};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-axis gyro band-pass IIR. Raw samples go in
// over a valid/ready channel with random gaps, and filtered rates come out
// with random back-pressure. A bit-exact fixed-point filter built into the
// scoreboard predicts every rate set. The run steps through reset, extreme,
// random and zero coefficient sets, and it covers rounding ties and
// saturation of both the history and the output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gyro_bp_pkg::*;

  // wide enough for the exact Q.52 sum of all five products
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [RATE_W-1:0] x;
    logic [RATE_W-1:0] y;
    logic [RATE_W-1:0] z;
  } rate_set_t;

  // how a side paces its handshakes
  typedef enum int unsigned {
    PACE_FULL,
    PACE_RANDOM,
    PACE_SPARSE
  } pace_e;

  localparam int unsigned MAX_GAP      = 19;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned PIPE_SETTLE  = 12;
  localparam longint      TIMEOUT_NS   = 10_000_000;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam logic [RAW_W-1:0]  RAW_MAX  = {1'b0, {(RAW_W-1){1'b1}}};
  localparam logic [RAW_W-1:0]  RAW_MIN  = {1'b1, {(RAW_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  localparam wide_t HIST_TOP    = (wide_t'(1) <<< (HIST_W-1)) - wide_t'(1);
  localparam wide_t HIST_BOTTOM = -(wide_t'(1) <<< (HIST_W-1));
  localparam wide_t RATE_TOP    = (wide_t'(1) <<< (RATE_W-1)) - wide_t'(1);
  localparam wide_t RATE_BOTTOM = -(wide_t'(1) <<< (RATE_W-1));

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [COEF_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [RAW_W-1:0]     raw_dev_x_i = '0;
  logic [RAW_W-1:0]     raw_dev_y_i = '0;
  logic [RAW_W-1:0]     raw_dev_z_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [RATE_W-1:0]    rate_x_o;
  logic [RATE_W-1:0]    rate_y_o;
  logic [RATE_W-1:0]    rate_z_o;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow coefficients and history, queue of rate sets due
  // --------------------------------------------------------------------------
  class bandpass_scoreboard;
    logic [COEF_W-1:0]                gain;
    logic [TAPS-1:0][COEF_W-1:0]      fb;    // [0] is the oldest tap
    logic [AXES*TAPS-1:0][HIST_W-1:0] hist;  // [axis*TAPS + tap], tap 0 oldest
    rate_set_t                        rates_due[$];
    int unsigned                      errors;
    int unsigned                      checked;
    int unsigned                      rail_hits;

    function new();
      gain    = RST_INPUT_GAIN;
      fb[0]   = RST_FEEDBACK_OLDEST;
      fb[1]   = RST_FEEDBACK_THIRD;
      fb[2]   = RST_FEEDBACK_SECOND;
      fb[3]   = RST_FEEDBACK_NEWEST;
      hist    = '0;
      errors  = 0;
      checked = 0;
      rail_hits = 0;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ns: MISMATCH %s", $time, what);
    endtask

    // unused indexes fall through and change nothing
    function void write_coef(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] val);
      case (idx)
        REG_INPUT_GAIN:      gain  = val;
        REG_FEEDBACK_OLDEST: fb[0] = val;
        REG_FEEDBACK_THIRD:  fb[1] = val;
        REG_FEEDBACK_SECOND: fb[2] = val;
        REG_FEEDBACK_NEWEST: fb[3] = val;
        default: ;
      endcase
    endfunction

    // one recursion step of one frame axis
    function logic [RATE_W-1:0] axis_rate(input axis_e ax, input logic [RAW_W-1:0] raw);
      wide_t acc, w, s;
      int    base;
      base = int'(ax) * TAPS;
      // raw * Q.28 gain is Q.28; lift to Q.52 to line up with history products
      acc = (wide_t'(signed'(raw)) * wide_t'(signed'(gain))) <<< 24;
      for (int tap = 0; tap < TAPS; tap++)
        acc += wide_t'(signed'(hist[base+tap])) * wide_t'(signed'(fb[tap]));
      // Q.52 -> Q.24, round half up, then clamp to the history width
      w = (acc + (wide_t'(1) <<< 27)) >>> 28;
      if (w > HIST_TOP) w = HIST_TOP;
      else if (w < HIST_BOTTOM) w = HIST_BOTTOM;
      // band-pass numerator: oldest + newest - 2 * middle
      s = wide_t'(signed'(hist[base])) + w - (wide_t'(signed'(hist[base+2])) <<< 1);
      hist[base]   = hist[base+1];
      hist[base+1] = hist[base+2];
      hist[base+2] = hist[base+3];
      hist[base+3] = w[HIST_W-1:0];
      // Q.24 -> Q15.16, round half up, saturate
      s = (s + wide_t'(128)) >>> 8;
      if (s > RATE_TOP) s = RATE_TOP;
      else if (s < RATE_BOTTOM) s = RATE_BOTTOM;
      return s[RATE_W-1:0];
    endfunction

    // device x and y trade places on the way to the frame axes
    function void sample_accepted(input logic [RAW_W-1:0] dx, dy, dz);
      rate_set_t due;
      due.x = axis_rate(AXIS_FX, dy);
      due.y = axis_rate(AXIS_FY, dx);
      due.z = axis_rate(AXIS_FZ, dz);
      rates_due.push_back(due);
    endfunction

    task check_field(input string name, input logic [RATE_W-1:0] got, want);
      if (got === RATE_TOP[RATE_W-1:0] || got === RATE_BOTTOM[RATE_W-1:0]) rail_hits++;
      if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
    endtask

    task rate_arrived(input logic [RATE_W-1:0] x, y, z);
      rate_set_t due;
      if (rates_due.size() == 0) begin
        report($sformatf("rate set %h %h %h with nothing due", x, y, z));
      end else begin
        due = rates_due.pop_front();
        check_field("rate_x", x, due.x);
        check_field("rate_y", y, due.y);
        check_field("rate_z", z, due.z);
        checked++;
      end
    endtask
  endclass

  bandpass_scoreboard sb;
  pace_e              src_pace = PACE_RANDOM;
  int unsigned        samples_sent = 0;
  int unsigned        settings_loaded = 0;

  three_axis_gyro_bandpass_iir dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_dev_x_i (raw_dev_x_i),
    .raw_dev_y_i (raw_dev_y_i),
    .raw_dev_z_i (raw_dev_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rate_x_o    (rate_x_o),
    .rate_y_o    (rate_y_o),
    .rate_z_o    (rate_z_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop if the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned draw_gap(input pace_e pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, MAX_GAP);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  // mix of full-range noise, drift around the last value, small counts
  // and the rails
  function automatic logic [RAW_W-1:0] draw_raw(input logic [RAW_W-1:0] last);
    case ($urandom_range(0, 9))
      4, 5:    return last + RAW_W'($urandom_range(0, 1023)) - RAW_W'(512);
      6:       return RAW_W'($urandom_range(0, 255)) - RAW_W'(128);
      7:       return $urandom_range(0, 1) ? RAW_MAX : RAW_MIN;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // result side: random stall before each item, then ready until taken
  initial begin
    int unsigned stall;
    int unsigned taken;
    pace_e       sink_pace;
    taken = 0;
    sink_pace = PACE_RANDOM;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) sink_pace = pace_e'($urandom_range(0, 2));
      stall = draw_gap(sink_pace);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      sb.rate_arrived(rate_x_o, rate_y_o, rate_z_o);
      taken++;
    end
  end

  task automatic send_item(input logic [RAW_W-1:0] x, y, z);
    int unsigned gap;
    gap = draw_gap(src_pace);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_dev_x_i <= x;
    raw_dev_y_i <= y;
    raw_dev_z_i <= z;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    sb.sample_accepted(x, y, z);
    samples_sent++;
  endtask

  // hold the input off until every rate set due has come out, then let the
  // pipeline settle
  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.rates_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.rates_due.size() != 0) begin
      sb.report($sformatf("%0d rate sets never came out", sb.rates_due.size()));
      sb.rates_due.delete();
    end
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  // write every index, the unused ones with junk that must be ignored;
  // only called with the block idle
  task automatic load_coefs(input logic [COEF_W-1:0] g, fo, f3, f2, fn);
    logic [COEF_W-1:0] vals [2**CFG_IDX_W];
    for (int i = 0; i < 2**CFG_IDX_W; i++) vals[i] = $urandom;
    vals[REG_INPUT_GAIN]      = g;
    vals[REG_FEEDBACK_OLDEST] = fo;
    vals[REG_FEEDBACK_THIRD]  = f3;
    vals[REG_FEEDBACK_SECOND] = f2;
    vals[REG_FEEDBACK_NEWEST] = fn;
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.write_coef(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic run_phase(input logic [COEF_W-1:0] g, fo, f3, f2, fn,
                           input int unsigned items);
    logic [RAW_W-1:0] px, py, pz;
    px = '0;
    py = '0;
    pz = '0;
    drain();
    load_coefs(g, fo, f3, f2, fn);
    for (int k = 0; k < items; k++) begin
      if (k % 64 == 0) src_pace = pace_e'($urandom_range(0, 2));
      // now and then wait for the pipeline to empty mid-stream
      if ($urandom_range(0, 99) == 0) drain();
      px = draw_raw(px);
      py = draw_raw(py);
      pz = draw_raw(pz);
      send_item(px, py, pz);
    end
  endtask

  function automatic logic [COEF_W-1:0] small_coef();
    return COEF_W'($urandom_range(0, 1 << 23)) - COEF_W'(1 << 22);
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rails and steps on the reset coefficients, nothing written yet
    send_item('0, '0, '0);
    send_item(RAW_MAX, RAW_MAX, RAW_MAX);
    send_item(RAW_MAX, RAW_MAX, RAW_MAX);
    send_item(RAW_MIN, RAW_MIN, RAW_MIN);
    send_item(RAW_MIN, RAW_MIN, RAW_MIN);
    send_item(RAW_MAX, RAW_MIN, 16'h0001);
    send_item(RAW_MIN, RAW_MAX, 16'hffff);
    send_item(16'h5555, 16'haaaa, 16'h00ff);
    send_item(16'haaaa, 16'h5555, 16'hff00);
    send_item('0, '0, '0);
    send_item('0, '0, '0);

    // gain of 8 with no feedback puts every odd count on a half-LSB tie
    // in the history rounding
    drain();
    load_coefs(32'd8, '0, '0, '0, '0);
    send_item(16'h0001, 16'h0001, 16'h0001);
    send_item(16'hffff, 16'hffff, 16'hffff);
    send_item(16'h0003, 16'hfffd, 16'h0005);
    send_item(16'hfffb, 16'h0007, 16'hfff9);

    // gain of 2048 makes w = 128 * raw: odd counts tie in the output rounding
    drain();
    load_coefs(32'd2048, '0, '0, '0, '0);
    send_item(16'h0001, 16'hffff, 16'h0003);
    send_item('0, '0, '0);
    send_item(16'hfffd, 16'h0005, 16'h0001);
    send_item(16'h0007, 16'hfff9, '0);

    // nominal filter, explicitly written
    run_phase(RST_INPUT_GAIN, RST_FEEDBACK_OLDEST, RST_FEEDBACK_THIRD,
              RST_FEEDBACK_SECOND, RST_FEEDBACK_NEWEST, 400);
    // gain at both rails drives the output into saturation
    run_phase(COEF_MAX, RST_FEEDBACK_OLDEST, RST_FEEDBACK_THIRD,
              RST_FEEDBACK_SECOND, RST_FEEDBACK_NEWEST, 80);
    run_phase(COEF_MIN, RST_FEEDBACK_OLDEST, RST_FEEDBACK_THIRD,
              RST_FEEDBACK_SECOND, RST_FEEDBACK_NEWEST, 80);
    // runaway feedback pins the history at its limits; zeros flush it
    run_phase(RST_INPUT_GAIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 60);
    run_phase('0, '0, '0, '0, '0, 8);
    run_phase(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 60);
    run_phase('0, '0, '0, '0, '0, 8);
    // arbitrary coefficients over the full range
    repeat (3) run_phase($urandom, $urandom, $urandom, $urandom, $urandom, 40);
    run_phase('0, '0, '0, '0, '0, 8);
    // small coefficients keep the recursion in range and exercise rounding
    repeat (2) run_phase(small_coef(), small_coef(), small_coef(), small_coef(),
                         small_coef(), 40);
    run_phase('0, '0, '0, '0, '0, 8);
    run_phase(RST_INPUT_GAIN, RST_FEEDBACK_OLDEST, RST_FEEDBACK_THIRD,
              RST_FEEDBACK_SECOND, RST_FEEDBACK_NEWEST, 550);

    drain();
    $display("%0d samples driven over %0d coefficient loads, %0d rate sets compared",
             samples_sent, settings_loaded, sb.checked);
    $display("%0d output rates hit a saturation rail, %0d mismatches",
             sb.rail_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
